### sv/hrlp_pkg.sv
// Package for the HTTP request line parser: beat types, phase and method codes,
// method name tables. Depends on nothing; imported by every module of the block.
`default_nettype none

package hrlp_pkg;

	// Input beat: one request byte and its end marker
	typedef struct packed {
		logic [7:0] request_byte;
		logic       end_of_request;
	} req_item_t;

	// Output beat: route byte or final summary
	typedef struct packed {
		logic       item_kind;
		logic [7:0] route_byte;
		logic [2:0] method_code;
		logic [7:0] route_length;
		logic       malformed;
	} res_item_t;

	// Parse phases
	localparam logic [1:0] PH_METHOD = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_ROUTE  = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Method codes as reported on the summary
	localparam logic [2:0] METHOD_UNKNOWN = 3'd0;
	localparam logic [2:0] METHOD_GET     = 3'd1;
	localparam logic [2:0] METHOD_POST    = 3'd2;
	localparam logic [2:0] METHOD_PUT     = 3'd3;
	localparam logic [2:0] METHOD_DELETE  = 3'd4;

	// Candidate slots in the live mask
	localparam logic [1:0] CAND_GET    = 2'd0;
	localparam logic [1:0] CAND_POST   = 2'd1;
	localparam logic [1:0] CAND_PUT    = 2'd2;
	localparam logic [1:0] CAND_DELETE = 2'd3;

	localparam int unsigned NUM_CAND = 4;

	// Item kinds
	localparam logic KIND_ROUTE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Method names, left-justified in six byte slots
	localparam logic [47:0] TEXT_GET    = {"GET", 24'h0};
	localparam logic [47:0] TEXT_POST   = {"POST", 16'h0};
	localparam logic [47:0] TEXT_PUT    = {"PUT", 24'h0};
	localparam logic [47:0] TEXT_DELETE = "DELETE";

	// Length of a candidate's method name
	function automatic logic [2:0] method_len(input logic [1:0] cand);
		logic [2:0] len;
		case (cand)
			CAND_GET:    len = 3'd3;
			CAND_POST:   len = 3'd4;
			CAND_PUT:    len = 3'd3;
			default:     len = 3'd6;
		endcase
		return len;
	endfunction

	// Character of a candidate's method name at a position
	function automatic logic [7:0] method_char(input logic [1:0] cand, input logic [2:0] pos);
		logic [47:0] txt;
		logic [7:0]  ch;
		case (cand)
			CAND_GET:  txt = TEXT_GET;
			CAND_POST: txt = TEXT_POST;
			CAND_PUT:  txt = TEXT_PUT;
			default:   txt = TEXT_DELETE;
		endcase
		case (pos)
			3'd0:    ch = txt[47:40];
			3'd1:    ch = txt[39:32];
			3'd2:    ch = txt[31:24];
			3'd3:    ch = txt[23:16];
			3'd4:    ch = txt[15:8];
			3'd5:    ch = txt[7:0];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

### sv/hrlp_core.sv
// Parse state and per-beat step logic of the HTTP request line parser.
// Depends on hrlp_pkg; instantiated by http_request_line_parser.
`default_nettype none

module hrlp_core
	import hrlp_pkg::*;
#(
	parameter int MAX_ROUTE = 256
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire req_item_t item,
	output logic           emit,
	output res_item_t      result
);

	localparam logic [7:0] ROUTE_LIMIT = 8'(MAX_ROUTE - 1);

	logic [2:0] byte_pos_q;
	logic [3:0] cand_mask_q;
	logic [1:0] phase_q;
	logic [2:0] method_q;
	logic [7:0] route_count_q;

	logic [2:0] byte_pos_d;
	logic [3:0] cand_mask_d;
	logic [1:0] phase_d;
	logic [2:0] method_d;
	logic [7:0] route_count_d;

	logic [3:0] live;
	logic       found;
	logic [2:0] found_code;
	logic       last;
	logic [7:0] b;

	assign b    = item.request_byte;
	assign last = item.end_of_request;

	// Match the byte against every live candidate and pick the first complete one
	always_comb begin
		live       = '0;
		found      = 1'b0;
		found_code = METHOD_UNKNOWN;
		for (int i = 0; i < NUM_CAND; i++) begin
			live[i] = cand_mask_q[i] && ({1'b0, byte_pos_q} < {1'b0, method_len(2'(i))})
				&& (b == method_char(2'(i), byte_pos_q));
		end
		for (int i = NUM_CAND - 1; i >= 0; i--) begin
			if (live[i] && ({1'b0, byte_pos_q} + 4'd1 == {1'b0, method_len(2'(i))})) begin
				found      = 1'b1;
				found_code = 3'(i + 1);
			end
		end
	end

	// Step the phase machine and form the result beat
	always_comb begin
		byte_pos_d    = byte_pos_q;
		cand_mask_d   = cand_mask_q;
		phase_d       = phase_q;
		method_d      = method_q;
		route_count_d = route_count_q;
		emit          = 1'b0;
		result        = '0;
		unique case (phase_q)
			PH_METHOD: begin
				cand_mask_d = live;
				if (found) begin
					method_d = found_code;
					phase_d  = PH_SKIP;
				end else if (live == 4'b0000) begin
					method_d = METHOD_UNKNOWN;
					emit     = 1'b1;
					phase_d  = PH_DONE;
				end else begin
					byte_pos_d = byte_pos_q + 3'd1;
				end
				if (last) begin
					emit = 1'b1;
				end
				result.item_kind = KIND_SUMMARY;
				result.malformed = 1'b1;
			end
			PH_SKIP: begin
				phase_d          = PH_ROUTE;
				emit             = last;
				result.item_kind = KIND_SUMMARY;
				result.malformed = 1'b1;
			end
			PH_ROUTE: begin
				emit = 1'b1;
				if (b == CHAR_SPACE) begin
					result.item_kind = KIND_SUMMARY;
					phase_d          = PH_DONE;
				end else if (last || route_count_q >= ROUTE_LIMIT) begin
					result.item_kind = KIND_SUMMARY;
					result.malformed = 1'b1;
					phase_d          = PH_DONE;
				end else begin
					route_count_d     = route_count_q + 8'd1;
					result.item_kind  = KIND_ROUTE;
					result.route_byte = b;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		result.method_code  = method_d;
		result.route_length = route_count_d;
	end

	// Advance the parse state; return to start after the end-marked byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q    <= '0;
			cand_mask_q   <= 4'b1111;
			phase_q       <= PH_METHOD;
			method_q      <= METHOD_UNKNOWN;
			route_count_q <= '0;
		end else if (advance) begin
			if (last) begin
				byte_pos_q    <= '0;
				cand_mask_q   <= 4'b1111;
				phase_q       <= PH_METHOD;
				method_q      <= METHOD_UNKNOWN;
				route_count_q <= '0;
			end else begin
				byte_pos_q    <= byte_pos_d;
				cand_mask_q   <= cand_mask_d;
				phase_q       <= phase_d;
				method_q      <= method_d;
				route_count_q <= route_count_d;
			end
		end
	end

endmodule

`default_nettype wire

### sv/http_request_line_parser.sv
// Top level of the HTTP request line parser: input stage, parse core, result register.
// Depends on hrlp_pkg and hrlp_core.
//
//   Channel  | Handshake            | Beat
//   ---------+----------------------+------------------------------------------
//   request  | req_valid/req_ready  | req_data: request_byte, end_of_request
//   result   | res_valid/res_ready  | res_data: kind, route byte, method, length, bad
//
// One byte per cycle while the result side does not stall; a byte taken is held in the
// input stage and parsed into the result register once the result slot is free.
// Reset returns the parser to method matching with all four methods live and empties
// both stages. A stall on the result side holds the input stage; bytes that yield no
// result still wait for a free result slot, so the pipeline stays in order.
`default_nettype none

module http_request_line_parser
	import hrlp_pkg::*;
#(
	parameter int MAX_ROUTE = 256
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req_data,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_item_t      res_data
);

	logic      valid_s1;
	req_item_t item_s1;
	logic      valid_s2;
	res_item_t item_s2;

	logic      slot_free;
	logic      advance;
	logic      emit;
	res_item_t step_result;

	// Move the held beat on whenever the result slot can take it
	assign slot_free = !valid_s2 || res_ready;
	assign advance   = valid_s1 && slot_free;
	assign req_ready = !valid_s1 || slot_free;

	// Hold the accepted request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_data;
		end
	end

	hrlp_core #(
		.MAX_ROUTE(MAX_ROUTE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.emit   (emit),
		.result (step_result)
	);

	// Load the result register; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			item_s2 <= step_result;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = item_s2;

endmodule

`default_nettype wire

### dv/tb_http_request_line_parser.sv
`timescale 1ns / 100ps
// Testbench for the HTTP request line parser: a directed table of request beats, then random
// requests, each result checked field by field against the table or a behavioural model.
// Depends on hrlp_pkg and http_request_line_parser.

module tb_http_request_line_parser;
	import hrlp_pkg::*;

	localparam int MAX_ROUTE   = 256;
	localparam int ITEMS       = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 8;

	// Method names and lengths per candidate slot, GET in slot 0
	localparam logic [3:0][47:0] NAMES     = {TEXT_DELETE, TEXT_PUT, TEXT_POST, TEXT_GET};
	localparam logic [3:0][2:0]  NAME_LEN  = {3'd6, 3'd3, 3'd4, 3'd3};
	localparam logic [3:0][2:0]  METHOD_OF = {METHOD_DELETE, METHOD_PUT, METHOD_POST, METHOD_GET};

	typedef struct packed {
		req_item_t beat;
		logic      typed;
		logic      gives;
		res_item_t res;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req_data;
	logic      res_valid;
	logic      res_ready;
	res_item_t res_data;

	// Parser model state
	logic [2:0] pm_pos;
	logic [3:0] pm_live;
	logic [1:0] pm_phase;
	logic [2:0] pm_method;
	logic [7:0] pm_count;

	res_item_t  pending_results[$];
	int         mismatches;
	int         counted_beats;
	int         cycles;
	bit         calm;

	http_request_line_parser #(
		.MAX_ROUTE(MAX_ROUTE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always #4 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void parser_clear();
		pm_pos    = 3'd0;
		pm_live   = 4'hF;
		pm_phase  = PH_METHOD;
		pm_method = METHOD_UNKNOWN;
		pm_count  = 8'd0;
	endfunction

	function automatic res_item_t summary(input logic [2:0] method, input logic [7:0] len,
			input logic bad);
		return '{KIND_SUMMARY, 8'h00, method, len, bad};
	endfunction

	// Advance the parser model by one beat; return 1 when the beat yields a result
	function automatic bit parse_beat(input req_item_t beat, output res_item_t res);
		int p;
		bit found;
		bit got;
		found = 1'b0;
		got   = 1'b0;
		res   = '0;
		case (pm_phase)
			PH_METHOD: begin
				p = int'(pm_pos);
				// drop every candidate whose name does not match here
				for (int i = 0; i < 4; i++) begin
					if (pm_live[i]) begin
						if (p >= int'(NAME_LEN[i]))
							pm_live[i] = 1'b0;
						else if (beat.request_byte != NAMES[i][8 * (5 - p) +: 8])
							pm_live[i] = 1'b0;
					end
				end
				for (int i = 0; i < 4; i++) begin
					if (!found && pm_live[i] && p + 1 == int'(NAME_LEN[i])) begin
						pm_method = METHOD_OF[i];
						pm_phase  = PH_SKIP;
						found     = 1'b1;
					end
				end
				if (!found) begin
					if (pm_live == 4'h0) begin
						pm_method = METHOD_UNKNOWN;
						res       = summary(pm_method, pm_count, 1'b1);
						got       = 1'b1;
						pm_phase  = PH_DONE;
					end else begin
						pm_pos = pm_pos + 3'd1;
					end
				end
				if (beat.end_of_request && !got) begin
					res = summary(pm_method, pm_count, 1'b1);
					got = 1'b1;
				end
			end
			PH_SKIP: begin
				pm_phase = PH_ROUTE;
				if (beat.end_of_request) begin
					res = summary(pm_method, pm_count, 1'b1);
					got = 1'b1;
				end
			end
			PH_ROUTE: begin
				got = 1'b1;
				if (beat.request_byte == CHAR_SPACE) begin
					res      = summary(pm_method, pm_count, 1'b0);
					pm_phase = PH_DONE;
				end else if (beat.end_of_request || int'(pm_count) >= MAX_ROUTE - 1) begin
					res      = summary(pm_method, pm_count, 1'b1);
					pm_phase = PH_DONE;
				end else begin
					pm_count = pm_count + 8'd1;
					res      = '{KIND_ROUTE, beat.request_byte, pm_method, pm_count, 1'b0};
				end
			end
			default: ;
		endcase
		if (beat.end_of_request)
			parser_clear();
		return got;
	endfunction

	function automatic req_item_t beat_of(input logic [7:0] b);
		return '{b, 1'b0};
	endfunction

	function automatic plan_row_t row(input logic [7:0] b, input logic eor, input logic typed,
			input logic gives, input res_item_t r);
		return '{'{b, eor}, typed, gives, r};
	endfunction

	// Present one beat, hold it until taken, then log what it should produce
	task automatic send_beat(input req_item_t beat, input logic typed, input logic gives,
			input res_item_t typed_res);
		int gap;
		bit has;
		res_item_t res;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= beat;
		do @(posedge clk); while (!req_ready);
		has = parse_beat(beat, res);
		if (typed) begin
			has = gives;
			res = typed_res;
		end
		if (has)
			pending_results.push_back(res);
		counted_beats++;
	endtask

	// Build and send one request: mostly well formed, some cut short, misspelt or noise
	task automatic random_request(input bit force_long);
		req_item_t q[$];
		int sel;
		int m;
		int n;
		int cut;
		logic [7:0] b;
		sel = force_long ? 0 : $urandom_range(0, 99);
		m   = $urandom_range(0, 3);
		for (int k = 0; k < int'(NAME_LEN[m]); k++)
			q.push_back(beat_of(NAMES[m][8 * (5 - k) +: 8]));
		q.push_back(beat_of(($urandom_range(0, 3) != 0) ? CHAR_SPACE : 8'($urandom_range(0, 255))));
		if (force_long)
			n = $urandom_range(256, 258);
		else if ($urandom_range(0, 149) == 0)
			n = $urandom_range(253, 258);
		else
			n = $urandom_range(0, 12);
		repeat (n) begin
			do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
			q.push_back(beat_of(b));
		end
		if ($urandom_range(0, 5) != 0)
			q.push_back(beat_of(CHAR_SPACE));
		repeat ($urandom_range(0, 3))
			q.push_back(beat_of(8'($urandom_range(0, 255))));
		if (sel >= 70 && sel < 85) begin
			// cut short anywhere
			cut = $urandom_range(1, q.size());
			while (q.size() > cut)
				void'(q.pop_back());
		end else if (sel >= 85 && sel < 93) begin
			// flip one bit of the method name
			cut = $urandom_range(0, int'(NAME_LEN[m]) - 1);
			q[cut].request_byte[$urandom_range(0, 7)] ^= 1'b1;
		end else if (sel >= 93) begin
			// plain noise
			q.delete();
			repeat ($urandom_range(1, 6))
				q.push_back(beat_of(8'($urandom_range(0, 255))));
		end
		q[q.size() - 1].end_of_request = 1'b1;
		foreach (q[k])
			send_beat(q[k], 1'b0, 1'b0, '0);
	endtask

	// Result side: stall a random number of cycles before each beat
	initial begin
		int stall;
		res_ready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	// Check every result beat against the oldest pending one
	always @(posedge clk) begin : check_results
		res_item_t want;
		bit differs;
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: kind %0d byte %02h method %0d len %0d bad %0d",
						res_data.item_kind, res_data.route_byte, res_data.method_code,
						res_data.route_length, res_data.malformed);
			end else begin
				want    = pending_results.pop_front();
				differs = (res_data.item_kind !== want.item_kind)
					|| (res_data.route_byte !== want.route_byte)
					|| (res_data.method_code !== want.method_code)
					|| (res_data.route_length !== want.route_length)
					|| (res_data.malformed !== want.malformed);
				if (differs) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d byte %02h method %0d len %0d bad %0d, %s",
							want.item_kind, want.route_byte, want.method_code,
							want.route_length, want.malformed,
							$sformatf("got kind %0d byte %02h method %0d len %0d bad %0d",
							res_data.item_kind, res_data.route_byte, res_data.method_code,
							res_data.route_length, res_data.malformed));
				end
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		mismatches    = 0;
		counted_beats = 0;
		cycles        = 0;
		calm          = 1'b0;
		parser_clear();

		// Directed requests: unknown method, GET with extreme route bytes and a space on the
		// last beat, POST ending on the separator, DELETE ending on a route beat, PUT ending on
		// the last method letter, bytes after a summary
		plan.push_back(row("X", 1'b0, 1'b1, 1'b1, summary(METHOD_UNKNOWN, 8'd0, 1'b1)));
		plan.push_back(row("Y", 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(row("G", 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(row("E", 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(row("T", 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(row(" ", 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(row(8'hFF, 1'b0, 1'b1, 1'b1, '{KIND_ROUTE, 8'hFF, METHOD_GET, 8'd1, 1'b0}));
		plan.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row(" ", 1'b1, 1'b1, 1'b1, summary(METHOD_GET, 8'd2, 1'b0)));
		plan.push_back(row("P", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("O", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("S", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("T", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row(" ", 1'b1, 1'b1, 1'b1, summary(METHOD_POST, 8'd0, 1'b1)));
		plan.push_back(row("D", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("E", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("L", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("E", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("T", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("E", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("/", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("a", 1'b1, 1'b1, 1'b1, summary(METHOD_DELETE, 8'd0, 1'b1)));
		plan.push_back(row("P", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("U", 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(row("T", 1'b1, 1'b1, 1'b1, summary(METHOD_PUT, 8'd0, 1'b1)));

		// Hold reset, release it on a rising edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			send_beat(plan[k].beat, plan[k].typed, plan[k].gives, plan[k].res);

		// Random requests; one early request runs past the route limit
		for (int r = 0; counted_beats < ITEMS; r++) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			if (r == 30) begin
				// hold off until the pipeline has drained
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			random_request(r == 5);
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
